>>> rtl/tdf_pkg.sv
`default_nettype none
package tdf_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic load;
		logic emit_none;
		logic div_step;
		logic emit_div;
		logic emit_rest;
		logic reduce;
		logic bump;
	} ctl_t;

endpackage
`default_nettype wire

>>> rtl/trial_division_factorizer.sv
// inputs below 2 give their single result in the cycle after the transfer
// otherwise each trial division is a bit-serial divider pass followed by a decide state:
// one trial per candidate and one per factor found, about sqrt(value) trials
// one input at a time: busy falls in the cycle the last result is strobed, next transfer then
// results are registered, one cycle each on valid; the receiver cannot stall
// reset: arst_n asynchronous active low, returns to idle with valid low
`default_nettype none
module trial_division_factorizer #(
	parameter int VALUE_BITS = 31
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [VALUE_BITS-1:0] value,
	output logic                       valid,
	output logic [VALUE_BITS-1:0]      factor,
	output logic                       no_factors,
	output logic                       last
);
	import tdf_pkg::*;

	localparam int CNT_BITS = $clog2(VALUE_BITS);
	localparam logic [CNT_BITS-1:0] CNT_TOP = CNT_BITS'(VALUE_BITS - 1);

	state_t                state_q, state_d;
	ctl_t                  ctl;
	logic [VALUE_BITS-1:0] n_q, d_q, quo_q, rem_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [VALUE_BITS:0]   trial;
	logic                  fits;
	logic                  valid_q, none_q, last_q;
	logic [VALUE_BITS-1:0] factor_q;

	// restoring divider step: one quotient bit per cycle
	assign trial = {rem_q, quo_q[VALUE_BITS-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && (value > VALUE_BITS'(1)))
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == '0)
					state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (quo_q < d_q)
					state_d = ST_IDLE;
				else
					state_d = ST_DIV;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (value > VALUE_BITS'(1))
						ctl.load = 1'b1;
					else
						ctl.emit_none = 1'b1;
				end
			end
			ST_DIV: ctl.div_step = 1'b1;
			ST_DECIDE: begin
				if (quo_q < d_q)
					ctl.emit_rest = 1'b1;
				else if (rem_q == '0) begin
					ctl.emit_div = 1'b1;
					ctl.reduce   = 1'b1;
				end else
					ctl.bump = 1'b1;
			end
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= ctl.emit_none | ctl.emit_div | ctl.emit_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			n_q   <= value;
			quo_q <= value;
			d_q   <= VALUE_BITS'(2);
			rem_q <= '0;
			cnt_q <= CNT_TOP;
		end else if (ctl.div_step) begin
			rem_q <= fits ? VALUE_BITS'(trial - {1'b0, d_q}) : trial[VALUE_BITS-1:0];
			quo_q <= {quo_q[VALUE_BITS-2:0], fits};
			cnt_q <= cnt_q - CNT_BITS'(1);
		end else if (ctl.reduce) begin
			n_q   <= quo_q;
			rem_q <= '0;
			cnt_q <= CNT_TOP;
		end else if (ctl.bump) begin
			d_q   <= d_q + VALUE_BITS'(1);
			quo_q <= n_q;
			rem_q <= '0;
			cnt_q <= CNT_TOP;
		end
		if (ctl.emit_none) begin
			factor_q <= '0;
			none_q   <= 1'b1;
			last_q   <= 1'b1;
		end else if (ctl.emit_div) begin
			factor_q <= d_q;
			none_q   <= 1'b0;
			last_q   <= 1'b0;
		end else if (ctl.emit_rest) begin
			factor_q <= n_q;
			none_q   <= 1'b0;
			last_q   <= 1'b1;
		end
	end

	assign busy       = state_q != ST_IDLE;
	assign valid      = valid_q;
	assign factor     = factor_q;
	assign no_factors = none_q;
	assign last       = last_q;

	// small inputs answer at once without leaving idle
	a_small_input: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && value < VALUE_BITS'(2)) |=> (valid && no_factors && last && !busy))
		else $error("small input not answered with no-factor result");

	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && no_factors) |-> (last && factor == '0))
		else $error("no-factor result malformed");

	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last) |-> busy)
		else $error("non-final factor while idle");

	a_factor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !no_factors) |-> (factor > VALUE_BITS'(1)))
		else $error("factor below two");

	a_divisor_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) |-> (d_q > VALUE_BITS'(1)))
		else $error("candidate divisor below two");

endmodule
`default_nettype wire

>>> dv/trial_division_factorizer_checker.sv
module trial_division_factorizer_checker #(
	parameter int VALUE_BITS = 31
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  busy,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic                  valid,
	input  wire logic [VALUE_BITS-1:0] factor,
	input  wire logic                  no_factors,
	input  wire logic                  last,
	output int                         errors,
	output int                         outstanding
);

	typedef struct packed {
		logic [VALUE_BITS-1:0] factor;
		logic                  no_factors;
		logic                  last;
	} factor_result_t;

	factor_result_t expected_factors [$];
	int mismatch_count = 0;
	int pending_count = 0;

	assign errors      = mismatch_count;
	assign outstanding = pending_count;

	function automatic void predict_factors(input logic [VALUE_BITS-1:0] number);
		longint unsigned cofactor;
		longint unsigned divisor;
		factor_result_t  res;
		cofactor = 64'(number);
		divisor  = 2;
		if (cofactor < 2) begin
			res.factor     = '0;
			res.no_factors = 1'b1;
			res.last       = 1'b1;
			expected_factors.push_back(res);
			return;
		end
		while (divisor <= cofactor / divisor) begin
			if (cofactor % divisor == 0) begin
				cofactor       = cofactor / divisor;
				res.factor     = VALUE_BITS'(divisor);
				res.no_factors = 1'b0;
				res.last       = 1'b0;
				expected_factors.push_back(res);
			end else begin
				divisor++;
			end
		end
		// remaining cofactor is prime
		res.factor     = VALUE_BITS'(cofactor);
		res.no_factors = 1'b0;
		res.last       = 1'b1;
		expected_factors.push_back(res);
	endfunction

	always @(posedge clk) begin
		factor_result_t want;
		if (arst_n) begin
			if (valid) begin
				if (expected_factors.size() == 0) begin
					$display("%0t extra result: expected none, actual factor %0d none %0b last %0b",
						$time, factor, no_factors, last);
					mismatch_count++;
				end else begin
					want = expected_factors.pop_front();
					if (factor !== want.factor) begin
						$display("%0t factor: expected %0d, actual %0d", $time, want.factor, factor);
						mismatch_count++;
					end
					if (no_factors !== want.no_factors) begin
						$display("%0t no_factors: expected %0b, actual %0b", $time,
							want.no_factors, no_factors);
						mismatch_count++;
					end
					if (last !== want.last) begin
						$display("%0t last: expected %0b, actual %0b", $time, want.last, last);
						mismatch_count++;
					end
				end
			end
			// input transfer
			if (start && !busy) begin
				predict_factors(value);
			end
			pending_count <= expected_factors.size();
		end
	end

endmodule

>>> dv/trial_division_factorizer_tb.sv
module trial_division_factorizer_tb;

	localparam int VB = 31;
	localparam longint unsigned MAX_DIVISOR = 600;
	localparam int NUM_DIRECTED = 24;
	localparam int PHASE_ITEMS = 19;

	localparam logic [VB-1:0] DIRECTED_VALUES [NUM_DIRECTED] = '{
		31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd8,
		31'd9, 31'd12, 31'd30, 31'd49, 31'd97, 31'd121, 31'd1024, 31'd65521,
		31'd65536, 31'd1073741824, 31'd1162261467, 31'd2000000000,
		31'd2147483646, 31'd1431655765, 31'd715827882, 31'd223092870
	};

	localparam int PHASE_IDLE [4] = '{0, 56, 0, 35};

	logic          clk;
	logic          arst_n = 1'b0;
	logic          start  = 1'b0;
	logic [VB-1:0] value  = '0;
	logic          busy;
	logic          valid;
	logic [VB-1:0] factor;
	logic          no_factors;
	logic          last;
	int            errors;
	int            outstanding;

	trial_division_factorizer #(
		.VALUE_BITS(VB)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.valid     (valid),
		.factor    (factor),
		.no_factors(no_factors),
		.last      (last)
	);

	trial_division_factorizer_checker #(
		.VALUE_BITS(VB)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.valid      (valid),
		.factor     (factor),
		.no_factors (no_factors),
		.last       (last),
		.errors     (errors),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("** trial_division_factorizer: FAILED **");
		$finish;
	end

	// keeps the trial division short so the run stays bounded
	function automatic bit quick_to_factor(input logic [VB-1:0] number);
		longint unsigned cofactor;
		longint unsigned divisor;
		cofactor = 64'(number);
		divisor  = 2;
		while (divisor <= cofactor / divisor) begin
			if (divisor > MAX_DIVISOR) begin
				return 1'b0;
			end
			if (cofactor % divisor == 0) begin
				cofactor = cofactor / divisor;
			end else begin
				divisor++;
			end
		end
		return 1'b1;
	endfunction

	function automatic logic [VB-1:0] random_value();
		logic [VB-1:0] number;
		int unsigned   bits;
		do begin
			bits   = ($urandom_range(0, 9) < 4) ? $urandom_range(1, 16) : $urandom_range(1, VB);
			number = VB'($urandom()) & VB'((64'd1 << bits) - 1);
		end while (!quick_to_factor(number));
		return number;
	endfunction

	task automatic send_value(input logic [VB-1:0] number, input int idle_pct);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			if ($urandom_range(0, 1) == 1) begin
				while (busy) @(posedge clk);
			end
			while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
		end
		start <= 1'b1;
		value <= number;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_VALUES[i]) begin
			send_value(DIRECTED_VALUES[i], 0);
		end

		for (int phase = 0; phase < 4; phase++) begin
			drain_results();
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_value(random_value(), PHASE_IDLE[phase]);
			end
		end

		drain_results();
		repeat (4 * (VB + 1)) @(posedge clk);

		if (errors == 0 && outstanding == 0) begin
			$display("** trial_division_factorizer: PASSED **");
		end else begin
			$display("** trial_division_factorizer: FAILED **");
		end
		$finish;
	end

endmodule
